// File: hdl/pirdema_pkg.sv
// Package with the shared types and constants of the PIR dual-average motion detector.
package pirdema_pkg;

  localparam int SAMPLE_BITS    = 14;
  localparam int WEIGHT_BITS    = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef logic [WEIGHT_BITS-1:0]    weight_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_addr_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_BAND_LOWER  = 3'd1,
    CFG_BAND_UPPER  = 3'd2,
    CFG_FAST_WEIGHT = 3'd3,
    CFG_SLOW_WEIGHT = 3'd4
  } cfg_index_t;

  localparam sample_t RST_THRESHOLD   = sample_t'(1500);
  localparam sample_t RST_BAND_LOWER  = sample_t'(3000);
  localparam sample_t RST_BAND_UPPER  = sample_t'(14000);
  localparam weight_t RST_FAST_WEIGHT = weight_t'(6554);
  localparam weight_t RST_SLOW_WEIGHT = weight_t'(66);
  localparam sample_t RST_AVERAGE     = sample_t'(8000);

  typedef struct packed {
    logic    mode;
    sample_t sample_value;
  } req_t;

  typedef struct packed {
    sample_t level_out;
    logic    motion_flag;
    logic    sample_in_band;
  } rsp_t;

  typedef struct packed {
    sample_t threshold;
    sample_t band_lower;
    sample_t band_upper;
    weight_t fast_weight;
    weight_t slow_weight;
  } cfg_t;

endpackage

// File: hdl/pir_dual_ema_motion_detector.sv
// Top level of the PIR dual exponential-average motion detector.
//
// Each beat on the request channel is either a sensor sample or a read-and-clear of the
// sticky motion flag, and produces exactly one response beat. A new request is taken in
// every cycle while the response channel is not stalled; a request passes through the
// request register and then the response register. The rate is set by the update of the
// fast and slow averages, the level and the flag, which is combinational between the request
// register and the response register and feeds the next request through the state
// registers. Configuration writes take effect on the next clock and must only be made
// while no request is in flight.
module pir_dual_ema_motion_detector
  import pirdema_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_t      req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_t      rsp,
  input  logic      cfg_write,
  input  cfg_addr_t cfg_index,
  input  cfg_data_t cfg_data
);

  cfg_t    cfg;
  logic    stage_valid;
  req_t    stage;
  logic    advance;
  sample_t fast_average;
  sample_t slow_average;
  sample_t current_level;
  logic    motion_latched;
  sample_t fast_average_next;
  sample_t slow_average_next;
  sample_t level_next;
  logic    latched_next;
  logic    in_band;

  pirdema_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pirdema_ema u_fast_ema (
    .weight       (cfg.fast_weight),
    .sample       (stage.sample_value),
    .average      (fast_average),
    .average_next (fast_average_next)
  );

  pirdema_ema u_slow_ema (
    .weight       (cfg.slow_weight),
    .sample       (stage.sample_value),
    .average      (slow_average),
    .average_next (slow_average_next)
  );

  assign advance   = stage_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = stage_valid && !advance;

  always_comb begin
    in_band = !stage.mode && (stage.sample_value > cfg.band_lower)
              && (stage.sample_value < cfg.band_upper);
    if (fast_average_next >= slow_average_next) begin
      level_next = fast_average_next - slow_average_next;
    end else begin
      level_next = slow_average_next - fast_average_next;
    end
    latched_next = motion_latched || (level_next > cfg.threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      rsp_valid      <= 1'b0;
      fast_average   <= RST_AVERAGE;
      slow_average   <= RST_AVERAGE;
      current_level  <= '0;
      motion_latched <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        stage_valid <= 1'b1;
        stage       <= req;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end

      if (advance) begin
        rsp_valid <= 1'b1;
        if (in_band) begin
          fast_average       <= fast_average_next;
          slow_average       <= slow_average_next;
          current_level      <= level_next;
          motion_latched     <= latched_next;
          rsp.level_out      <= level_next;
          rsp.motion_flag    <= latched_next;
          rsp.sample_in_band <= 1'b1;
        end else begin
          if (stage.mode) begin
            motion_latched <= 1'b0;
          end
          rsp.level_out      <= current_level;
          rsp.motion_flag    <= motion_latched;
          rsp.sample_in_band <= 1'b0;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/pirdema_cfg_regs.sv
// Configuration register file of the motion detector.
module pirdema_cfg_regs
  import pirdema_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  cfg_addr_t cfg_index,
  input  cfg_data_t cfg_data,
  output cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold   <= RST_THRESHOLD;
      cfg.band_lower  <= RST_BAND_LOWER;
      cfg.band_upper  <= RST_BAND_UPPER;
      cfg.fast_weight <= RST_FAST_WEIGHT;
      cfg.slow_weight <= RST_SLOW_WEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_THRESHOLD:   cfg.threshold   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_BAND_LOWER:  cfg.band_lower  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_BAND_UPPER:  cfg.band_upper  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_FAST_WEIGHT: cfg.fast_weight <= cfg_data[WEIGHT_BITS-1:0];
        CFG_SLOW_WEIGHT: cfg.slow_weight <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/pirdema_ema.sv
// One exponential-average update: old + floor(w * (x - old) / 65536).
module pirdema_ema
  import pirdema_pkg::*;
(
  input  weight_t weight,
  input  sample_t sample,
  input  sample_t average,
  output sample_t average_next
);

  logic signed [SAMPLE_BITS:0]               diff;
  logic signed [WEIGHT_BITS+SAMPLE_BITS+1:0] prod;
  logic signed [SAMPLE_BITS+1:0]             step;
  logic signed [SAMPLE_BITS+1:0]             sum;

  // The identity w*x + (1-w)*old = old + w*(x-old) needs one signed product.
  always_comb begin
    diff = $signed({1'b0, sample}) - $signed({1'b0, average});
    prod = $signed({1'b0, weight}) * diff;
    step = prod[WEIGHT_BITS+SAMPLE_BITS+1:WEIGHT_BITS];
    sum  = $signed({2'b00, average}) + step;
    average_next = sum[SAMPLE_BITS-1:0];
  end

endmodule

// File: hdl/pirdema_checker.sv
// Port-level checker of the motion detector, bound to the top level.
module pirdema_checker
  import pirdema_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_t      rsp
);

  sample_t last_level;
  logic    last_flag;
  logic    rsp_beat;

  assign rsp_beat = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
      last_flag  <= 1'b0;
    end else if (rsp_beat) begin
      last_level <= rsp.level_out;
      last_flag  <= rsp.motion_flag;
    end
  end

  // A stalled response stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

  // The response register is empty right after reset.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A beat that is not an in-band sample leaves the level as it was.
  assert property (@(posedge clk) disable iff (rst)
    rsp_beat && !rsp.sample_in_band |-> rsp.level_out == last_level)
    else $error("level changed without an in-band sample");

  // The motion flag can only be raised by an in-band sample.
  assert property (@(posedge clk) disable iff (rst)
    rsp_beat && rsp.motion_flag && !rsp.sample_in_band |-> last_flag)
    else $error("motion flag raised without an in-band sample");

  // A request taken while the response side is empty passes the stage register and then shows in the response register.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
    else $error("accepted request produced no response");

endmodule

bind pir_dual_ema_motion_detector pirdema_checker u_checker (.*);

// File: test/tb.sv
// Self-checking testbench for the PIR dual exponential-average motion detector.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pirdema_pkg::*;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam int MAX_GAP       = 19;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 183;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int TIMEOUT_NS    = 2_000_000;

  class motion_scoreboard;
    sample_t thresh, band_lo, band_hi;
    weight_t w_fast, w_slow;
    sample_t avg_fast, avg_slow, level;
    logic    motion;
    rsp_t    expected_q[$];
    int      errors, checked, in_band_seen, flags_seen, reads_seen;

    function new();
      thresh   = RST_THRESHOLD;
      band_lo  = RST_BAND_LOWER;
      band_hi  = RST_BAND_UPPER;
      w_fast   = RST_FAST_WEIGHT;
      w_slow   = RST_SLOW_WEIGHT;
      avg_fast = RST_AVERAGE;
      avg_slow = RST_AVERAGE;
      level    = '0;
      motion   = 1'b0;
    endfunction

    function void write_reg(cfg_addr_t idx, cfg_data_t data);
      case (idx)
        CFG_THRESHOLD:   thresh  = data[SAMPLE_BITS-1:0];
        CFG_BAND_LOWER:  band_lo = data[SAMPLE_BITS-1:0];
        CFG_BAND_UPPER:  band_hi = data[SAMPLE_BITS-1:0];
        CFG_FAST_WEIGHT: w_fast  = data[WEIGHT_BITS-1:0];
        CFG_SLOW_WEIGHT: w_slow  = data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function sample_t blend(weight_t w, sample_t x, sample_t prev);
      logic [WEIGHT_BITS:0] keep;
      logic [33:0]          acc;
      keep = (17'd1 << WEIGHT_BITS) - {1'b0, w};
      acc  = 34'(w) * 34'(x) + 34'(keep) * 34'(prev);
      return acc[WEIGHT_BITS +: SAMPLE_BITS];
    endfunction

    function void note_request(req_t item);
      rsp_t want;
      want.sample_in_band = 1'b0;
      if (item.mode == MODE_SAMPLE) begin
        if (item.sample_value > band_lo && item.sample_value < band_hi) begin
          want.sample_in_band = 1'b1;
          avg_fast = blend(w_fast, item.sample_value, avg_fast);
          avg_slow = blend(w_slow, item.sample_value, avg_slow);
          level = (avg_fast >= avg_slow) ? avg_fast - avg_slow : avg_slow - avg_fast;
          if (level > thresh) begin
            motion = 1'b1;
          end
          in_band_seen++;
        end
        want.motion_flag = motion;
      end else begin
        want.motion_flag = motion;
        motion = 1'b0;
        reads_seen++;
      end
      want.level_out = level;
      if (want.motion_flag) begin
        flags_seen++;
      end
      expected_q.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual level %0d flag %0b in_band %0b",
                 $time, got.level_out, got.motion_flag, got.sample_in_band);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.level_out !== want.level_out) begin
        errors++;
        $display("%0t: level_out expected %0d actual %0d", $time, want.level_out, got.level_out);
      end
      if (got.motion_flag !== want.motion_flag) begin
        errors++;
        $display("%0t: motion_flag expected %0b actual %0b", $time, want.motion_flag,
                 got.motion_flag);
      end
      if (got.sample_in_band !== want.sample_in_band) begin
        errors++;
        $display("%0t: sample_in_band expected %0b actual %0b", $time, want.sample_in_band,
                 got.sample_in_band);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_t      req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_t      rsp;
  logic      cfg_write;
  cfg_addr_t cfg_index;
  cfg_data_t cfg_data;

  motion_scoreboard sb;
  bit send_calm;
  bit recv_calm;
  int wander;

  pir_dual_ema_motion_detector dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("pir_dual_ema_motion_detector: mismatch");
    $finish;
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic req_t make_req(logic m, int v);
    req_t item;
    item.mode = m;
    item.sample_value = sample_t'(v);
    return item;
  endfunction

  function automatic req_t next_item();
    req_t item;
    int   pick;
    int   lo;
    int   hi;
    lo = int'(sb.band_lo);
    hi = int'(sb.band_hi);
    pick = $urandom_range(0, 99);
    item.mode = MODE_SAMPLE;
    item.sample_value = sample_t'($urandom);
    if (pick < 12) begin
      item.mode = MODE_READ;
    end else if (pick < 22) begin
      item.mode = MODE_SAMPLE;
    end else if (pick < 30) begin
      case ($urandom_range(0, 5))
        0: item.sample_value = '0;
        1: item.sample_value = '1;
        2: item.sample_value = sample_t'(lo);
        3: item.sample_value = sample_t'(lo + 1);
        4: item.sample_value = sample_t'(hi - 1);
        default: item.sample_value = sample_t'(hi);
      endcase
    end else if (lo + 2 <= hi) begin
      if ($urandom_range(0, 19) == 0 || wander <= lo || wander >= hi) begin
        wander = $urandom_range(lo + 1, hi - 1);
      end
      item.sample_value = sample_t'(wander + int'($urandom_range(0, 40)) - 20);
    end
    return item;
  endfunction

  task automatic send_req(req_t item);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk) req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    sb.note_request(item);
  endtask

  task automatic drain();
    @(negedge clk) req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(cfg_addr_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(sample_t thr, sample_t lo, sample_t hi, weight_t wf,
                              weight_t ws);
    put_reg(CFG_THRESHOLD, (cfg_data_t'($urandom) << SAMPLE_BITS) | cfg_data_t'(thr));
    put_reg(CFG_BAND_LOWER, (cfg_data_t'($urandom) << SAMPLE_BITS) | cfg_data_t'(lo));
    put_reg(CFG_BAND_UPPER, (cfg_data_t'($urandom) << SAMPLE_BITS) | cfg_data_t'(hi));
    put_reg(CFG_FAST_WEIGHT, cfg_data_t'(wf));
    put_reg(CFG_SLOW_WEIGHT, cfg_data_t'(ws));
  endtask

  initial begin
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      int gap;
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        @(negedge clk) rsp_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      sb.check_response(rsp);
    end
  end

  initial begin
    req_t    directed[$];
    sample_t thr, lo, hi;
    weight_t wf, ws;

    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    wander = 8000;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    directed.push_back(make_req(MODE_SAMPLE, 0));
    directed.push_back(make_req(MODE_SAMPLE, 16383));
    directed.push_back(make_req(MODE_SAMPLE, 3000));
    directed.push_back(make_req(MODE_SAMPLE, 14000));
    directed.push_back(make_req(MODE_READ, 0));
    directed.push_back(make_req(MODE_SAMPLE, 3001));
    repeat (7) directed.push_back(make_req(MODE_SAMPLE, 13999));
    directed.push_back(make_req(MODE_SAMPLE, 2999));
    directed.push_back(make_req(MODE_READ, 16383));
    directed.push_back(make_req(MODE_READ, 5000));
    repeat (6) directed.push_back(make_req(MODE_SAMPLE, 3001));
    directed.push_back(make_req(MODE_READ, 0));
    foreach (directed[i]) begin
      send_req(directed[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: program_regs('0, '0, '1, '1, weight_t'(1));
        1: program_regs('1, sample_t'(5000), sample_t'(5001), '0, '0);
        2: program_regs(sample_t'(100), sample_t'(5000), sample_t'(5002), '0, '1);
        PHASES - 1: program_regs(RST_THRESHOLD, RST_BAND_LOWER, RST_BAND_UPPER,
                                 RST_FAST_WEIGHT, RST_SLOW_WEIGHT);
        default: begin
          thr = ($urandom_range(0, 3) == 0) ? sample_t'($urandom)
                                            : sample_t'($urandom_range(200, 2500));
          lo = sample_t'($urandom_range(0, 8000));
          hi = sample_t'($urandom_range(int'(lo) + 2, 16383));
          wf = ($urandom_range(0, 3) == 0) ? weight_t'($urandom)
                                           : weight_t'($urandom_range(2000, 30000));
          ws = ($urandom_range(0, 3) == 0) ? weight_t'($urandom)
                                           : weight_t'($urandom_range(0, 1500));
          program_regs(thr, lo, hi, wf, ws);
        end
      endcase
      if (p == 1) begin
        for (int k = int'(CFG_SLOW_WEIGHT) + 1; k < 2 ** CFG_INDEX_BITS; k++) begin
          put_reg(cfg_addr_t'(k), cfg_data_t'($urandom));
        end
      end
      @(negedge clk) cfg_write <= 1'b0;
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 3 && i == 60) || $urandom_range(0, 149) == 0) begin
          drain();
        end
        send_req(next_item());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d response beats over %0d register settings, the reset values included.",
             sb.checked, PHASES + 1);
    $display("Of these, %0d samples fell inside the band, %0d were reads, %0d showed motion.",
             sb.in_band_seen, sb.reads_seen, sb.flags_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pir_dual_ema_motion_detector: match");
    end else begin
      $display("pir_dual_ema_motion_detector: mismatch");
    end
    $finish;
  end
endmodule
